@@ design/bilinear_line_resampler_defines.svh @@
// Assertion macros for the bilinear line resampler.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef BILINEAR_LINE_RESAMPLER_DEFINES_SVH
`define BILINEAR_LINE_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("resampler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("resampler assertion failed");

`endif

@@ design/brs_pkg.sv @@
// Shared types, codes and blend arithmetic for the bilinear line resampler.
// No dependencies.
package brs_pkg;

	localparam int FRAC_BITS = 10;
	localparam int POS_W     = 23;  // start_offset + x * step
	localparam int LX_W      = 14;  // source entry index incl. +1 and +2
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W    = 2;

	localparam logic [1:0] OP_WRITE_CUR  = 2'd0;
	localparam logic [1:0] OP_WRITE_NEXT = 2'd1;
	localparam logic [1:0] OP_OUTPUT     = 2'd2;
	localparam logic [1:0] OP_UNUSED     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_START   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_END     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VFRAC        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_EN     = 3'd6;

	localparam logic [11:0] STEP_RESET = 12'h400;

	typedef enum logic [1:0] {
		K_WRITE_CUR,
		K_WRITE_NEXT,
		K_OUTPUT
	} kind_t;

	// One classified item as it travels from front to back.
	typedef struct packed {
		kind_t            kind;
		logic [LX_W-1:0]  addr;     // write entry, or centre entry for output
		logic [31:0]      word;
		logic [9:0]       x;
		logic [7:0]       prior;
		logic [4:0]       xf;
		logic [4:0]       yf;
		logic             oob;
		logic             blend;    // horizontal blend stage active
		logic             vblend;   // vertical blend stage active
	} desc_t;

	// a + (((b - a) * f + 16) >> 5), flooring shift, modulo 256
	function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
			input logic [4:0] f);
		logic signed [8:0]  diff;
		logic signed [14:0] acc;
		logic signed [9:0]  q;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		acc  = 15'(diff) * 15'($signed({1'b0, f})) + 15'sd16;
		q    = 10'(acc >>> 5);
		return a + q[7:0];
	endfunction

	function automatic logic [23:0] blend_rgb(input logic [23:0] a, input logic [23:0] b,
			input logic [4:0] f);
		logic [23:0] res;
		for (int c = 0; c < 3; c++) begin
			res[c*8 +: 8] = blend_channel(a[c*8 +: 8], b[c*8 +: 8], f);
		end
		return res;
	endfunction

endpackage

@@ design/brs_if.sv @@
// Channel interfaces of the bilinear line resampler: input items, results, config writes.
// Depends on brs_pkg for field widths.
interface brs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [9:0] line_index;
	logic [31:0] pixel_word;
	logic [9:0] out_position;
	logic [7:0] prior_alpha;

	modport source (output valid, operation, line_index, pixel_word, out_position,
		prior_alpha, input ready);
	modport sink (input valid, operation, line_index, pixel_word, out_position,
		prior_alpha, output ready);
endinterface

interface brs_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] result_position;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, result_position, red, green, blue, alpha, input ready);
	modport sink (input valid, result_position, red, green, blue, alpha, output ready);
endinterface

interface brs_cfg_if import brs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/brs_front.sv @@
// Front part: config registers, item classification and source position computation.
// Depends on brs_pkg and the channel interfaces in brs_if.sv.
module brs_front import brs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	brs_in_if.sink     pix_in,
	brs_cfg_if.sink    cfg,
	output logic       push_valid,
	input  logic       push_ready,
	output desc_t      push_desc
);

	logic [9:0]  line_width_q;
	logic [9:0]  pass_start_q;
	logic [9:0]  pass_end_q;
	logic [19:0] start_offset_q;
	logic [11:0] step_q;
	logic [4:0]  vfrac_q;
	logic        blend_en_q;

	logic [21:0]      prod;
	logic [POS_W-1:0] pos;
	logic             keep;
	logic             any_frac;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= '0;
			pass_start_q   <= '0;
			pass_end_q     <= '0;
			start_offset_q <= '0;
			step_q         <= STEP_RESET;
			vfrac_q        <= '0;
			blend_en_q     <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINE_WIDTH:   line_width_q   <= cfg.data[9:0];
				REG_PASS_START:   pass_start_q   <= cfg.data[9:0];
				REG_PASS_END:     pass_end_q     <= cfg.data[9:0];
				REG_START_OFFSET: start_offset_q <= cfg.data[19:0];
				REG_STEP:         step_q         <= cfg.data[11:0];
				REG_VFRAC:        vfrac_q        <= cfg.data[4:0];
				REG_BLEND_EN:     blend_en_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign prod = 22'(pix_in.out_position) * 22'(step_q);
	assign pos  = POS_W'(start_offset_q) + POS_W'(prod);
	assign any_frac = (pos[FRAC_BITS-1 -: 5] != 5'd0) || (vfrac_q != 5'd0);

	// Drop the unused code and requests past the row end; they give nothing.
	always_comb begin
		keep = 1'b0;
		push_desc = '0;
		push_desc.word  = pix_in.pixel_word;
		push_desc.x     = pix_in.out_position;
		push_desc.prior = pix_in.prior_alpha;
		push_desc.xf    = pos[FRAC_BITS-1 -: 5];
		push_desc.yf    = vfrac_q;
		case (pix_in.operation)
			OP_WRITE_CUR: begin
				keep = 1'b1;
				push_desc.kind = K_WRITE_CUR;
				push_desc.addr = LX_W'(pix_in.line_index);
			end
			OP_WRITE_NEXT: begin
				keep = 1'b1;
				push_desc.kind = K_WRITE_NEXT;
				push_desc.addr = LX_W'(pix_in.line_index);
			end
			OP_OUTPUT: begin
				keep = pix_in.out_position < line_width_q;
				push_desc.kind   = K_OUTPUT;
				push_desc.addr   = LX_W'(pos[POS_W-1:FRAC_BITS]) + LX_W'(1);
				push_desc.oob    = (pix_in.out_position < pass_start_q) ||
					(pix_in.out_position >= pass_end_q);
				push_desc.blend  = blend_en_q && any_frac;
				push_desc.vblend = blend_en_q && (vfrac_q != 5'd0);
			end
			default: keep = 1'b0;
		endcase
	end

	assign pix_in.ready = push_ready;
	assign push_valid   = pix_in.valid && keep;

endmodule

@@ design/brs_queue.sv @@
// Short FIFO of classified items between the front and back parts.
// Depends on brs_pkg for the item descriptor type.
module brs_queue import brs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  desc_t push_desc,
	output logic  pop_valid,
	input  logic  pop_ready,
	output desc_t pop_desc
);

	desc_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_desc   = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/brs_back.sv @@
// Back part: line stores, store reads, vertical blend, horizontal blend, result register.
// Depends on brs_pkg for the descriptor type and blend functions.
module brs_back import brs_pkg::*; #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pop_valid,
	output logic   pop_ready,
	input  desc_t  pop_desc,
	brs_out_if.source pix_out
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam logic [LX_W-1:0] DEPTH_L = LX_W'(LINE_DEPTH);

	logic [31:0] cur_mem [LINE_DEPTH];
	logic [31:0] nxt_mem [LINE_DEPTH];

	logic            adv;
	logic [LX_W-1:0] addr1;
	logic            fire_wr_cur;
	logic            fire_wr_nxt;

	// stage 1: store read
	logic        valid_s1;
	logic [31:0] cur0_s1, cur1_s1, nxt0_s1, nxt1_s1;
	logic        ok0_s1, ok1_s1;
	logic [9:0]  x_s1;
	logic [7:0]  prior_s1;
	logic [4:0]  xf_s1, yf_s1;
	logic        oob_s1, blend_s1, vblend_s1;

	// stage 2: vertical blend
	logic        valid_s2;
	logic [23:0] ctr_s2, rgt_s2;
	logic [7:0]  alpha_s2;
	logic [9:0]  x_s2;
	logic [7:0]  prior_s2;
	logic [4:0]  xf_s2;
	logic        oob_s2, blend_s2;

	logic [31:0] c0, c1, n0, n1;

	// result register
	logic        out_valid_q;
	logic [9:0]  out_pos_q;
	logic [23:0] out_rgb_q;
	logic [7:0]  out_alpha_q;

	assign adv       = !out_valid_q || pix_out.ready;
	assign pop_ready = adv;
	assign addr1     = pop_desc.addr + LX_W'(1);

	assign fire_wr_cur = adv && pop_valid && (pop_desc.kind == K_WRITE_CUR) &&
		(pop_desc.addr < DEPTH_L);
	assign fire_wr_nxt = adv && pop_valid && (pop_desc.kind == K_WRITE_NEXT) &&
		(pop_desc.addr < DEPTH_L);

	always_ff @(posedge clk) begin
		if (fire_wr_cur) begin
			cur_mem[pop_desc.addr[AW-1:0]] <= pop_desc.word;
		end
		if (adv) begin
			cur0_s1 <= cur_mem[pop_desc.addr[AW-1:0]];
			cur1_s1 <= cur_mem[addr1[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (fire_wr_nxt) begin
			nxt_mem[pop_desc.addr[AW-1:0]] <= pop_desc.word;
		end
		if (adv) begin
			nxt0_s1 <= nxt_mem[pop_desc.addr[AW-1:0]];
			nxt1_s1 <= nxt_mem[addr1[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok0_s1    <= pop_desc.addr < DEPTH_L;
			ok1_s1    <= addr1 < DEPTH_L;
			x_s1      <= pop_desc.x;
			prior_s1  <= pop_desc.prior;
			xf_s1     <= pop_desc.xf;
			yf_s1     <= pop_desc.yf;
			oob_s1    <= pop_desc.oob;
			blend_s1  <= pop_desc.blend;
			vblend_s1 <= pop_desc.vblend;
		end
	end

	// Entries past the store read as zero.
	assign c0 = ok0_s1 ? cur0_s1 : '0;
	assign c1 = ok1_s1 ? cur1_s1 : '0;
	assign n0 = ok0_s1 ? nxt0_s1 : '0;
	assign n1 = ok1_s1 ? nxt1_s1 : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctr_s2   <= vblend_s1 ? blend_rgb(c0[23:0], n0[23:0], yf_s1) : c0[23:0];
			rgt_s2   <= vblend_s1 ? blend_rgb(c1[23:0], n1[23:0], yf_s1) : c1[23:0];
			alpha_s2 <= c0[31:24];
			x_s2     <= x_s1;
			prior_s2 <= prior_s1;
			xf_s2    <= xf_s1;
			oob_s2   <= oob_s1;
			blend_s2 <= blend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pos_q <= x_s2;
			if (oob_s2) begin
				out_rgb_q   <= '0;
				out_alpha_q <= prior_s2;
			end else begin
				out_rgb_q   <= blend_s2 ? blend_rgb(ctr_s2, rgt_s2, xf_s2) : ctr_s2;
				out_alpha_q <= alpha_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop_valid && (pop_desc.kind == K_OUTPUT);
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign pix_out.valid           = out_valid_q;
	assign pix_out.result_position = out_pos_q;
	assign pix_out.red             = out_rgb_q[23:16];
	assign pix_out.green           = out_rgb_q[15:8];
	assign pix_out.blue            = out_rgb_q[7:0];
	assign pix_out.alpha           = out_alpha_q;

endmodule

@@ design/bilinear_line_resampler.sv @@
// Bilinear line resampler top level. Throughput: one item per cycle while results drain.
// Path: an output request accepted into the queue moves through the queue, the store read,
// the vertical blend and the horizontal blend into the result register.
// Line store writes give no result; the back part writes the store as it pops them.
// Reset: config registers to their defaults, queue and pipeline valids cleared;
// line stores are not reset and hold no meaning until written.
`include "bilinear_line_resampler_defines.svh"

module bilinear_line_resampler import brs_pkg::*; #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	brs_in_if.sink     pix_in,
	brs_out_if.source  pix_out,
	brs_cfg_if.sink    cfg
);

	logic  q_push_valid;
	logic  q_push_ready;
	desc_t q_push_desc;
	logic  q_pop_valid;
	logic  q_pop_ready;
	desc_t q_pop_desc;

	brs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.cfg        (cfg),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_desc  (q_push_desc)
	);

	brs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_desc  (q_push_desc),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_desc   (q_pop_desc)
	);

	brs_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_desc  (q_pop_desc),
		.pix_out   (pix_out)
	);

	`BRS_ASSERT_SAME(a_unused_op_dropped, pix_in.valid && pix_in.operation == OP_UNUSED, !q_push_valid)
	`BRS_ASSERT_SAME(a_full_queue_stalls_input, !q_push_ready, !pix_in.ready)
	`BRS_ASSERT_NEXT(a_queue_head_held, q_pop_valid && !q_pop_ready, q_pop_valid)

endmodule
